### rtl/tbp_pkg.sv
// Shared constants for the tournament branch predictor.
package tbp_pkg;

  localparam int INDEX_BITS_DEF   = 16;
  localparam int COUNTER_BITS_DEF = 2;

  // Global history register and its length register.
  localparam int HIST_MAX_LEN = 20;
  localparam int HIST_LEN_W   = 5;
  localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = HIST_LEN_W'(HIST_MAX_LEN);

  // Chooser: values 2 and 3 select the global table.
  localparam int CHOOSER_W = 2;
  localparam logic [CHOOSER_W-1:0] CHOOSER_RESET = 2'd2;
  localparam logic [CHOOSER_W-1:0] CHOOSER_MAX   = 2'd3;

  // Result packing, highest bit first.
  localparam int RES_W     = 4;
  localparam int OUT_TDATA_W = 8;
  localparam int IN_TDATA_W  = 72;
  localparam int PC_W        = 64;

  typedef struct packed {
    logic used_global;
    logic global_guess;
    logic local_guess;
    logic predict_taken;
  } tbp_result_t;

endpackage

### rtl/tbp_ram.sv
// Generic simple dual-port RAM with registered read data.
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/tournament_branch_predictor_unit.sv
// Tournament branch predictor: each request is one resolved branch (PC and outcome). The block
// reports the bimodal (PC-indexed) guess, the gshare (PC fold XOR history) guess, which one the
// single 2-bit chooser picked, and the chosen prediction, all formed before its own update.
// It takes one request per clock while no clearing pass runs and the output queue has room: the
// counter tables are synchronous RAMs read in the accept cycle and written back in the next
// one, with a bypass of the last write. A two-entry output queue keeps the input open while a
// result waits. After reset a clearing pass sets every table entry to weakly taken, and
// in_tready stays low until it is done. history_length may be written at any idle time and
// takes effect for the next request.
module tournament_branch_predictor_unit #(
  parameter int INDEX_BITS   = tbp_pkg::INDEX_BITS_DEF,
  parameter int COUNTER_BITS = tbp_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: history_length.
  input  logic                            cfg_wr_en,
  input  logic [tbp_pkg::HIST_LEN_W-1:0]  cfg_wr_data,
  // Request: [63:0] branch_pc, [64] was_taken, [71:65] zero.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tbp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Result: [0] predict_taken, [1] local_guess, [2] global_guess, [3] used_global, [7:4] zero.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tbp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import tbp_pkg::*;

  localparam int DEPTH = 1 << INDEX_BITS;
  localparam int KEY_W = (INDEX_BITS > HIST_MAX_LEN) ? INDEX_BITS : HIST_MAX_LEN;
  localparam logic [COUNTER_BITS-1:0] CTR_HALF = COUNTER_BITS'(1 << (COUNTER_BITS - 1));
  localparam logic [COUNTER_BITS-1:0] CTR_MAX  = '1;

  function automatic logic [COUNTER_BITS-1:0] ctr_step(input logic [COUNTER_BITS-1:0] v,
                                                       input logic up);
    logic [COUNTER_BITS-1:0] r;
    r = v;
    if (up) begin
      if (v != CTR_MAX) r = v + 1'b1;
    end else begin
      if (v != '0) r = v - 1'b1;
    end
    return r;
  endfunction

  // Configuration and global state.
  logic [HIST_LEN_W-1:0]   hist_len_r;
  logic [HIST_MAX_LEN-1:0] hist_r, hist_nxt;
  logic [CHOOSER_W-1:0]    chooser_r, chooser_nxt;

  // Clearing pass.
  logic                    clr_busy_r;
  logic [INDEX_BITS-1:0]   clr_idx_r;

  // Read stage.
  logic                    s1_valid_r;
  logic [INDEX_BITS-1:0]   s1_li_r, s1_gi_r;
  logic                    s1_taken_r;

  // Last write to each table, for the read-during-write bypass.
  logic                    lwl_valid_r, lwg_valid_r;
  logic [INDEX_BITS-1:0]   lwl_addr_r, lwg_addr_r;
  logic [COUNTER_BITS-1:0] lwl_data_r, lwg_data_r;

  // Output queue.
  tbp_result_t             q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0]              q_cnt_r, q_cnt_nxt;

  logic [PC_W-1:0]          pc;
  logic                     taken;
  logic [HIST_LEN_W-1:0]    eff_len;
  logic [HIST_MAX_LEN:0]    mask_wide;
  logic [HIST_MAX_LEN-1:0]  hist_mask, hist_cur;
  logic [15:0]              fold;
  logic [KEY_W-1:0]         gkey;
  logic [INDEX_BITS-1:0]    li, gi;
  logic                     in_fire, out_fire;
  logic [1:0]               occ;

  logic [COUNTER_BITS-1:0]  l_rdata, g_rdata, lctr, gctr, l_new, g_new;
  logic                     lp, gp, use_g;
  tbp_result_t              res;

  logic                     ram_we;
  logic [INDEX_BITS-1:0]    l_waddr, g_waddr;
  logic [COUNTER_BITS-1:0]  l_wdata, g_wdata;

  // Index formation from the request and the current history.
  assign pc        = in_tdata[PC_W-1:0];
  assign taken     = in_tdata[PC_W];
  assign eff_len   = (hist_len_r > HIST_LEN_W'(HIST_MAX_LEN)) ? HIST_LEN_W'(HIST_MAX_LEN)
                                                              : hist_len_r;
  assign mask_wide = ((HIST_MAX_LEN+1)'(1) << eff_len) - (HIST_MAX_LEN+1)'(1);
  assign hist_mask = mask_wide[HIST_MAX_LEN-1:0];
  assign hist_cur  = hist_r & hist_mask;
  assign fold      = pc[15:0] ^ pc[31:16] ^ pc[47:32] ^ pc[63:48];
  assign gkey      = KEY_W'(fold) ^ KEY_W'(hist_cur);
  assign gi        = gkey[INDEX_BITS-1:0];
  assign li        = pc[INDEX_BITS+1:2];
  assign hist_nxt  = ((hist_cur << 1) | HIST_MAX_LEN'(taken)) & hist_mask;

  // Handshakes. Occupancy counts results queued plus the one in the read stage.
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = {(OUT_TDATA_W-RES_W)'(0), q0_r};
  assign out_fire   = out_tvalid && out_tready;
  assign occ        = q_cnt_r + 2'(s1_valid_r);
  assign in_tready  = !clr_busy_r && ((occ < 2'd2) || out_fire);
  assign in_fire    = in_tvalid && in_tready;

  // Prediction and counter update for the item in the read stage.
  assign lctr  = (lwl_valid_r && lwl_addr_r == s1_li_r) ? lwl_data_r : l_rdata;
  assign gctr  = (lwg_valid_r && lwg_addr_r == s1_gi_r) ? lwg_data_r : g_rdata;
  assign lp    = lctr[COUNTER_BITS-1];
  assign gp    = gctr[COUNTER_BITS-1];
  assign use_g = chooser_r[CHOOSER_W-1];
  assign l_new = ctr_step(lctr, s1_taken_r);
  assign g_new = ctr_step(gctr, s1_taken_r);

  always_comb begin
    res.predict_taken = use_g ? gp : lp;
    res.local_guess   = lp;
    res.global_guess  = gp;
    res.used_global   = use_g;
  end

  // The chooser moves toward whichever table alone was right.
  always_comb begin
    chooser_nxt = chooser_r;
    if ((lp == s1_taken_r) && (gp != s1_taken_r)) begin
      if (chooser_r != '0) chooser_nxt = chooser_r - 1'b1;
    end else if ((lp != s1_taken_r) && (gp == s1_taken_r)) begin
      if (chooser_r != CHOOSER_MAX) chooser_nxt = chooser_r + 1'b1;
    end
  end

  // Table write port: clearing pass first, otherwise write-back.
  assign ram_we  = clr_busy_r || s1_valid_r;
  assign l_waddr = clr_busy_r ? clr_idx_r : s1_li_r;
  assign g_waddr = clr_busy_r ? clr_idx_r : s1_gi_r;
  assign l_wdata = clr_busy_r ? CTR_HALF : l_new;
  assign g_wdata = clr_busy_r ? CTR_HALF : g_new;

  tbp_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (DEPTH)
  ) u_local_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (li),
    .rdata (l_rdata)
  );

  tbp_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (DEPTH)
  ) u_global_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (gi),
    .rdata (g_rdata)
  );

  // Output queue: push from the read stage, pop to the result channel.
  always_comb begin
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    q_cnt_nxt = q_cnt_r;
    case ({s1_valid_r, out_fire})
      2'b10: begin
        if (q_cnt_r == 2'd0) q0_nxt = res;
        else                 q1_nxt = res;
        q_cnt_nxt = q_cnt_r + 2'd1;
      end
      2'b01: begin
        q0_nxt    = q1_r;
        q_cnt_nxt = q_cnt_r - 2'd1;
      end
      2'b11: begin
        if (q_cnt_r == 2'd1) begin
          q0_nxt = res;
        end else begin
          q0_nxt = q1_r;
          q1_nxt = res;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r  <= HIST_LEN_RESET;
      hist_r      <= '0;
      chooser_r   <= CHOOSER_RESET;
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      lwl_valid_r <= 1'b0;
      lwg_valid_r <= 1'b0;
      q_cnt_r     <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        hist_len_r <= cfg_wr_data;
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == '1) clr_busy_r <= 1'b0;
      end
      if (in_fire) begin
        hist_r <= hist_nxt;
      end
      if (s1_valid_r) begin
        chooser_r <= chooser_nxt;
      end
      if (ram_we) begin
        lwl_valid_r <= 1'b1;
        lwg_valid_r <= 1'b1;
      end
      s1_valid_r <= in_fire;
      q_cnt_r    <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_li_r    <= li;
    s1_gi_r    <= gi;
    s1_taken_r <= taken;
    q0_r       <= q0_nxt;
    q1_r       <= q1_nxt;
    if (ram_we) begin
      lwl_addr_r <= l_waddr;
      lwl_data_r <= l_wdata;
      lwg_addr_r <= g_waddr;
      lwg_data_r <= g_wdata;
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tournament branch predictor unit.
module tb_top;
  import tbp_pkg::*;

  localparam int IDX_W        = INDEX_BITS_DEF;
  localparam int CTR_W        = COUNTER_BITS_DEF;
  localparam int TABLE_DEPTH  = 1 << IDX_W;
  localparam logic [CTR_W-1:0] CTR_TOP = '1;
  localparam logic [CTR_W-1:0] CTR_MID = CTR_W'(1 << (CTR_W - 1));
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASES       = 9;
  localparam int NUM_ROWS     = 24;

  typedef enum logic {ROW_BRANCH, ROW_HIST_LEN} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [PC_W-1:0]         pc;
    logic                    taken;
    logic [HIST_LEN_W-1:0]   len;
    logic                    typed;
    tbp_result_t             want;
  } dir_row_t;

  // After reset every counter is weakly taken and the chooser picks the global table,
  // so the very first branch sees all four result bits set.
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_BRANCH,   64'h0000_0000_0000_0000, 1'b0, 5'd0,  1'b1, 4'hF},
    '{ROW_BRANCH,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h8000_0000_0000_0000, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0004, 1'b0, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0004, 1'b0, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0004, 1'b0, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0004, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0001_0001_0001_0001, 1'b0, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'hDEAD_BEEF_CAFE_F00C, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_HIST_LEN, 64'h0,                   1'b0, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0100, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0100, 1'b0, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0100, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_HIST_LEN, 64'h0,                   1'b0, 5'd31, 1'b0, 4'h0},
    '{ROW_BRANCH,   64'h5555_5555_5555_5555, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h5555_5555_5555_5555, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_HIST_LEN, 64'h0,                   1'b0, 5'd3,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0040, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0040, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0000_0040, 1'b0, 5'd0,  1'b0, 4'h0},
    '{ROW_HIST_LEN, 64'h0,                   1'b0, 5'd20, 1'b0, 4'h0},
    '{ROW_BRANCH,   64'h7FFF_FFFF_FFFF_FFFC, 1'b1, 5'd0,  1'b0, 4'h0},
    '{ROW_BRANCH,   64'h0000_0000_0003_FFFC, 1'b0, 5'd0,  1'b0, 4'h0}
  };

  localparam logic [HIST_LEN_W-1:0] PHASE_LENS [PHASES] = '{
    5'd1, 5'd20, 5'd0, 5'd7, 5'd31, 5'd16, 5'd17, 5'd2, 5'd20
  };

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [HIST_LEN_W-1:0]  cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predictor state, kept in step with the block.
  logic [CTR_W-1:0]        bimodal_ctr [TABLE_DEPTH];
  logic [CTR_W-1:0]        gshare_ctr  [TABLE_DEPTH];
  logic [HIST_MAX_LEN-1:0] branch_history;
  logic [CHOOSER_W-1:0]    chooser;
  logic [HIST_LEN_W-1:0]   history_len;

  tbp_result_t pending_results [$];
  int          fail_count   = 0;
  bit          steady_phase = 1'b0;

  tournament_branch_predictor_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [CTR_W-1:0] saturate_step(logic [CTR_W-1:0] v, logic up);
    if (up) begin
      return (v == CTR_TOP) ? v : v + 1'b1;
    end
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // Forms the three guesses from the current state, then trains chooser, tables and history.
  function automatic tbp_result_t predict_branch(logic [PC_W-1:0] pc, logic taken);
    int                      eff_len;
    logic [HIST_MAX_LEN-1:0] hmask;
    logic [HIST_MAX_LEN-1:0] hist;
    logic [15:0]             fold;
    logic [IDX_W-1:0]        li;
    logic [IDX_W-1:0]        gi;
    logic                    lok;
    logic                    gok;
    tbp_result_t             r;
    eff_len = (history_len > HIST_MAX_LEN) ? HIST_MAX_LEN : int'(history_len);
    hmask   = HIST_MAX_LEN'((32'd1 << eff_len) - 32'd1);
    hist    = branch_history & hmask;
    fold    = pc[15:0] ^ pc[31:16] ^ pc[47:32] ^ pc[63:48];
    li      = pc[IDX_W+1:2];
    gi      = IDX_W'(32'(fold) ^ 32'(hist));

    r.local_guess   = bimodal_ctr[li] >= CTR_MID;
    r.global_guess  = gshare_ctr[gi] >= CTR_MID;
    r.used_global   = chooser >= CHOOSER_RESET;
    r.predict_taken = r.used_global ? r.global_guess : r.local_guess;

    lok = (r.local_guess == taken);
    gok = (r.global_guess == taken);
    if (lok && !gok && chooser != '0) begin
      chooser = chooser - 1'b1;
    end
    if (!lok && gok && chooser != CHOOSER_MAX) begin
      chooser = chooser + 1'b1;
    end
    bimodal_ctr[li] = saturate_step(bimodal_ctr[li], taken);
    gshare_ctr[gi]  = saturate_step(gshare_ctr[gi], taken);
    branch_history  = ((hist << 1) | HIST_MAX_LEN'(taken)) & hmask;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_phase || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Valid is left high after a request is taken; the next call or a drain decides what follows.
  task automatic issue_branch(input logic [PC_W-1:0] pc, input logic taken,
                              input logic typed, input tbp_result_t want);
    int          gap;
    tbp_result_t model_res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - PC_W - 1){1'b0}}, taken, pc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_res = predict_branch(pc, taken);
    pending_results.push_back(typed ? want : model_res);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_history_length(input logic [HIST_LEN_W-1:0] len);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    history_len  = len;
  endtask

  // Result side: ready held high for a while, then at times dropped for a random stall.
  initial begin
    int run;
    int gap;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    tbp_result_t got;
    tbp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = tbp_result_t'(out_tdata[RES_W-1:0]);
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding: %0h", out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.predict_taken !== want.predict_taken) begin
          $error("predict_taken: expected %0b, got %0b", want.predict_taken, got.predict_taken);
          fail_count++;
        end
        if (got.local_guess !== want.local_guess) begin
          $error("local_guess: expected %0b, got %0b", want.local_guess, got.local_guess);
          fail_count++;
        end
        if (got.global_guess !== want.global_guess) begin
          $error("global_guess: expected %0b, got %0b", want.global_guess, got.global_guess);
          fail_count++;
        end
        if (got.used_global !== want.used_global) begin
          $error("used_global: expected %0b, got %0b", want.used_global, got.used_global);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int                    i;
    int                    j;
    int                    phase;
    int                    sent;
    int                    trips;
    int                    pick;
    logic [PC_W-1:0]       hot_pcs [8];
    logic [PC_W-1:0]       pc_a;
    logic [PC_W-1:0]       pc_b;
    logic                  outcome;
    logic [HIST_LEN_W-1:0] len;

    for (i = 0; i < TABLE_DEPTH; i++) begin
      bimodal_ctr[i] = CTR_MID;
      gshare_ctr[i]  = CTR_MID;
    end
    branch_history = '0;
    chooser        = CHOOSER_RESET;
    history_len    = HIST_LEN_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_HIST_LEN) begin
        set_history_length(DIRECTED_ROWS[i].len);
      end else begin
        issue_branch(DIRECTED_ROWS[i].pc, DIRECTED_ROWS[i].taken,
                     DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
    end

    // Mostly loop-shaped and correlated branches on a few hot addresses, so that
    // counters saturate and the chooser travels both ways; the rest is noise.
    for (phase = 0; phase < PHASES; phase++) begin
      len = (phase == PHASES - 1) ? HIST_LEN_W'($urandom_range(0, 31)) : PHASE_LENS[phase];
      set_history_length(len);
      steady_phase = (phase % 4 == 3);
      for (j = 0; j < 8; j++) begin
        hot_pcs[j] = {$urandom, $urandom};
      end
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          pc_a  = hot_pcs[$urandom_range(0, 7)];
          trips = $urandom_range(1, 8);
          for (j = 0; j < trips; j++) begin
            issue_branch(pc_a, 1'b1, 1'b0, '0);
          end
          issue_branch(pc_a, 1'b0, 1'b0, '0);
          sent += trips + 1;
        end else if (pick < 80) begin
          pc_a    = hot_pcs[$urandom_range(0, 7)];
          pc_b    = hot_pcs[$urandom_range(0, 7)];
          outcome = 1'($urandom_range(0, 1));
          issue_branch(pc_a, outcome, 1'b0, '0);
          issue_branch(pc_b, outcome, 1'b0, '0);
          sent += 2;
        end else begin
          issue_branch({$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'b0, '0);
          sent += 1;
        end
      end
    end
    steady_phase = 1'b0;

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
